// ===== sv/rme_pkg.sv =====
`default_nettype none

package rme_pkg;

  // widths fixed by the item and register fields
  localparam int MSG_WIDTH         = 32;
  localparam int EXP_WIDTH         = 32;
  localparam int CFG_INDEX_WIDTH   = 2;
  localparam int MOD_WIDTH_DEFAULT = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS          = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PUBLIC_EXPONENT  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRIVATE_EXPONENT = 2'd2;

  // func field codes
  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  // request to the shared modular multiply unit
  typedef struct packed {
    logic start;
    logic reduce_only;
  } mm_ctrl_t;

  // status back from the shared unit
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

`default_nettype wire

// ===== sv/rme_channels.sv =====
`default_nettype none

interface rme_req_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [rme_pkg::MSG_WIDTH-1:0]  message;

  modport source (output valid, output func, output message, input ready);
  modport sink   (input valid, input func, input message, output ready);
endinterface

interface rme_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [rme_pkg::MSG_WIDTH-1:0]  result_value;

  modport source (output valid, output result_value, input ready);
  modport sink   (input valid, input result_value, output ready);
endinterface

interface rme_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [rme_pkg::CFG_INDEX_WIDTH-1:0]  index;
  logic [rme_pkg::EXP_WIDTH-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/rsa_modular_exponentiation.sv =====
`default_nettype none

// channel    role    direction  payload
// request    sink    in         func, message
// response   source  out        result_value
// cfg        sink    in         index, data (modulus, public / private exponent)
//
// one item at a time; request is ready only while the sequencer is idle
// per item: unless the modulus is zero, the message is reduced first, then for each
//   exponent bit up to the highest set one a square of base with its step, plus a
//   multiply of acc by base where the bit is set
// all of this work runs on the shared multiply unit, which reduces one bit a cycle
// synchronous active-high reset; configuration registers return to 1, no clearing pass
// a finished result waits in the response register, a new item is taken meanwhile

module rsa_modular_exponentiation #(
  parameter int MOD_WIDTH = rme_pkg::MOD_WIDTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  rme_req_if.sink  request,
  rme_rsp_if.source response,
  rme_cfg_if.sink  cfg
);

  localparam int EW = rme_pkg::EXP_WIDTH;
  localparam int MW = rme_pkg::MSG_WIDTH;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BASE = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]           state;

  // configuration registers, only the low bits of the modulus are kept
  logic [MOD_WIDTH-1:0] modulus;
  logic [EW-1:0]        public_exponent;
  logic [EW-1:0]        private_exponent;

  // working registers
  logic [EW-1:0]        expo;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] base;
  logic                 rsp_valid;
  logic [MW-1:0]        rsp_value;

  logic                 req_accept;
  logic                 rsp_load;
  logic                 mod_zero;
  logic                 mod_one;

  rme_pkg::mm_ctrl_t    mm_ctrl;
  rme_pkg::mm_status_t  mm_status;
  logic [MOD_WIDTH-1:0] mm_op_a;
  logic [MOD_WIDTH-1:0] mm_result;

  assign request.ready         = (state == S_IDLE);
  assign req_accept            = request.valid && request.ready;
  assign response.valid        = rsp_valid;
  assign response.result_value = rsp_value;
  assign cfg.ready             = 1'b1;

  // result goes out once the response register is free
  assign rsp_load = (state == S_FIN) && (!rsp_valid || response.ready);

  assign mod_zero = (modulus == '0);
  assign mod_one  = (modulus == MOD_WIDTH'(1));

  // unit requests: message reduction on accept, multiply or square per exponent bit
  always_comb begin
    mm_ctrl.reduce_only = (state == S_IDLE);
    mm_ctrl.start       = (req_accept && !mod_zero)
                       || (state == S_STEP && expo != '0)
                       || (state == S_MUL && mm_status.done);
    // multiply acc by base when the bit is set, otherwise square base
    mm_op_a = (state == S_STEP && expo[0]) ? acc : base;
  end

  rme_modmul #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mm_ctrl),
    .op_a    (mm_op_a),
    .op_b    (base),
    .value   (request.message),
    .modulus (modulus),
    .status  (mm_status),
    .result  (mm_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      rsp_valid        <= 1'b0;
      modulus          <= MOD_WIDTH'(1);
      public_exponent  <= EW'(1);
      private_exponent <= EW'(1);
    end else begin
      // register writes, indexes beyond the list are dropped
      if (cfg.valid) begin
        unique case (cfg.index)
          rme_pkg::REG_MODULUS:          modulus          <= cfg.data[MOD_WIDTH-1:0];
          rme_pkg::REG_PUBLIC_EXPONENT:  public_exponent  <= cfg.data;
          rme_pkg::REG_PRIVATE_EXPONENT: private_exponent <= cfg.data;
          default: ;
        endcase
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (response.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_accept) begin
            expo  <= (request.func == rme_pkg::FUNC_DECRYPT) ? private_exponent
                                                             : public_exponent;
            // one mod n, which is zero for a modulus of one
            acc   <= (mod_zero || mod_one) ? '0 : MOD_WIDTH'(1);
            // no reduction without a modulus: straight to a zero result
            state <= mod_zero ? S_FIN : S_BASE;
          end
        end
        S_BASE: begin
          if (mm_status.done) begin
            base  <= mm_result;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (expo == '0) begin
            state <= S_FIN;
          end else if (expo[0]) begin
            state <= S_MUL;
          end else begin
            state <= S_SQR;
          end
        end
        S_MUL: begin
          // the square is started in the same cycle
          if (mm_status.done) begin
            acc   <= mm_result;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (mm_status.done) begin
            base  <= mm_result;
            expo  <= expo >> 1;
            state <= S_STEP;
          end
        end
        S_FIN: begin
          // hold until the response register is free
          if (rsp_load) begin
            rsp_value <= MW'(acc);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/rme_modmul.sv =====
`default_nettype none

module rme_modmul #(
  parameter int MOD_WIDTH = rme_pkg::MOD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rme_pkg::mm_ctrl_t             ctrl,
  input  logic [MOD_WIDTH-1:0]          op_a,
  input  logic [MOD_WIDTH-1:0]          op_b,
  input  logic [rme_pkg::MSG_WIDTH-1:0] value,
  input  logic [MOD_WIDTH-1:0]          modulus,
  output rme_pkg::mm_status_t           status,
  output logic [MOD_WIDTH-1:0]          result
);

  localparam int PW    = 2 * MOD_WIDTH;
  localparam int SW    = rme_pkg::MSG_WIDTH;
  localparam int CNT_W = $clog2(SW + 1);

  localparam logic U_IDLE   = 1'b0;
  localparam logic U_REDUCE = 1'b1;

  logic             phase;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [MOD_WIDTH-1:0] rem;
  logic [SW-1:0]        shreg;

  logic [PW-1:0]        prod;
  logic [MOD_WIDTH:0]   trial;
  logic [MOD_WIDTH:0]   diff;

  // operands are below the modulus, so the high half is already reduced
  assign prod  = PW'(op_a) * PW'(op_b);
  assign trial = {rem, shreg[SW-1]};
  assign diff  = trial - {1'b0, modulus};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= U_IDLE;
      done  <= 1'b0;
    end else begin
      // pulse after the last division step
      done <= (phase == U_REDUCE) && (cnt == CNT_W'(1));
      unique case (phase)
        U_IDLE: begin
          if (ctrl.start) begin
            phase <= U_REDUCE;
            if (ctrl.reduce_only) begin
              rem   <= '0;
              shreg <= value;
              cnt   <= CNT_W'(SW);
            end else begin
              rem   <= prod[PW-1:MOD_WIDTH];
              shreg <= SW'(prod[MOD_WIDTH-1:0]) << (SW - MOD_WIDTH);
              cnt   <= CNT_W'(MOD_WIDTH);
            end
          end
        end
        U_REDUCE: begin
          // one restoring division step a cycle
          if (trial >= {1'b0, modulus}) begin
            rem <= diff[MOD_WIDTH-1:0];
          end else begin
            rem <= trial[MOD_WIDTH-1:0];
          end
          shreg <= shreg << 1;
          cnt   <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            phase <= U_IDLE;
          end
        end
        default: phase <= U_IDLE;
      endcase
    end
  end

  assign status.busy = (phase == U_REDUCE);
  assign status.done = done;
  assign result      = rem;

endmodule

`default_nettype wire
